[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VRSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VRSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/vrsa_pkg.sv]
// ----------------------------------------------------------------------------
// vrsa_pkg
// Types and constants of the variable range slot allocator.
// ----------------------------------------------------------------------------
package vrsa_pkg;

   localparam int ADDR_W     = 52;
   localparam int LEN_W      = 53;
   localparam int LG_W       = 6;
   localparam int TYPE_W     = 8;
   localparam int SIDX_W     = 3;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;
   localparam int NUM_W      = 4;

   localparam int MIN_LOG2      = 20;
   localparam int MAX_LOG2      = 52;
   localparam int VALID_POS     = 11;
   localparam int MIN_PAB       = 32;
   localparam int FALLBACK_BITS = 36;
   localparam int WIN_W         = 8;

   localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;
   localparam logic [ADDR_W-1:0] PAGE_MASK  = ~ADDR_W'(12'hFFF);
   localparam logic [ADDR_W-1:0] VALID_MASK = ADDR_W'(1) << VALID_POS;
   localparam logic [TYPE_W-1:0] WC_TYPE    = 8'd1;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_PRESET  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WC_SUPPORTED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SLOTS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHYS_ADDR_BITS = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STAT_NEW      = 3'd0,
      STAT_COVERED  = 3'd1,
      STAT_UNSUP    = 3'd2,
      STAT_NO_SLOTS = 3'd3,
      STAT_FULL     = 3'd4,
      STAT_PRESET   = 3'd5
   } status_type;

   typedef struct packed {
      logic            done;
      logic [LG_W-1:0] lg;
   } size_res_type;

endpackage

[src/variable_range_slot_allocator.sv]
// ----------------------------------------------------------------------------
// variable_range_slot_allocator
// Keeps a table of variable memory-range slots in a RAM. A request rounds
// its region to a power of two, scans the slots for a covering
// write-combining entry and otherwise claims the first invalid slot.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall opcode, base, length, slot, type
//   rsp      out        rsp_valid/rsp_stall status, slot, base, size, words
//   csr      in         csr_we              csr_index, csr_wdata
//
// One request at a time. The length search walks the byte windows, then come a
// setup step, a slot scan over the RAM read port (n usable slots, requests
// only) and an output step.
// The result sits in an output register, so the next request is taken while
// it waits. Reset is synchronous and marks every slot as never written.
// ----------------------------------------------------------------------------
module variable_range_slot_allocator #(
   parameter int MAX_SLOTS = 8,
   parameter int ADDR_BITS = 52
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [vrsa_pkg::ADDR_W-1:0]       req_phys_base,
   input  logic [vrsa_pkg::LEN_W-1:0]        req_length,
   input  logic [vrsa_pkg::SIDX_W-1:0]       req_slot_index,
   input  logic [vrsa_pkg::TYPE_W-1:0]       req_mem_type,
   input  logic                              req_valid_flag,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vrsa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [vrsa_pkg::SIDX_W-1:0]       rsp_slot_used,
   output logic [vrsa_pkg::ADDR_W-1:0]       rsp_region_base,
   output logic [vrsa_pkg::LG_W-1:0]         rsp_size_log2,
   output logic [vrsa_pkg::ADDR_W-1:0]       rsp_base_word,
   output logic [vrsa_pkg::ADDR_W-1:0]       rsp_mask_word,

   input  logic                              csr_we,
   input  logic [vrsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vrsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW    = $clog2(MAX_SLOTS + 1);
   localparam int AW    = vrsa_pkg::ADDR_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SIZE   = 6'b000010,
      S_PREP   = 6'b000100,
      S_SCAN   = 6'b001000,
      S_DECIDE = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                               csr_wc_ff, csr_wc_in;
   logic [vrsa_pkg::NUM_W-1:0]         csr_num_ff, csr_num_in;
   logic [vrsa_pkg::CSR_DATA_W-1:0]    csr_pab_ff, csr_pab_in;

   logic                               op_ff, op_in;
   logic [AW-1:0]                      base_ff, base_in;
   logic [vrsa_pkg::SIDX_W-1:0]        sidx_ff, sidx_in;
   logic [vrsa_pkg::TYPE_W-1:0]        mtype_ff, mtype_in;
   logic                               vflag_ff, vflag_in;
   logic                               wc_ff, wc_in;
   logic [CW-1:0]                      n_ff, n_in;
   logic [AW-1:0]                      pmask_ff, pmask_in;
   logic [vrsa_pkg::LG_W-1:0]          lg_ff, lg_in;
   logic [AW-1:0]                      abase_ff, abase_in;
   logic [AW-1:0]                      szmask_ff, szmask_in;

   logic [CW-1:0]                      iss_ff, iss_in;
   logic                               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                   rd_idx_ff, rd_idx_in;
   logic                               rd_wv_ff, rd_wv_in;
   logic                               rd_last_ff, rd_last_in;

   logic                               hit_ff, hit_in;
   logic [IDX_W-1:0]                   hit_slot_ff, hit_slot_in;
   logic [AW-1:0]                      hit_bw_ff, hit_bw_in;
   logic [AW-1:0]                      hit_mw_ff, hit_mw_in;
   logic                               free_ff, free_in;
   logic [IDX_W-1:0]                   free_slot_ff, free_slot_in;

   vrsa_pkg::status_type               status_ff, status_in;
   logic [IDX_W-1:0]                   slot_ff, slot_in;
   logic [AW-1:0]                      bw_ff, bw_in;
   logic [AW-1:0]                      mw_ff, mw_in;
   logic                               wr_ff, wr_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [vrsa_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [vrsa_pkg::SIDX_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [AW-1:0]                      rsp_abase_ff, rsp_abase_in;
   logic [vrsa_pkg::LG_W-1:0]          rsp_lg_ff, rsp_lg_in;
   logic [AW-1:0]                      rsp_bw_ff, rsp_bw_in;
   logic [AW-1:0]                      rsp_mw_ff, rsp_mw_in;

   logic [MAX_SLOTS-1:0]               written_ff, written_in;

   logic                               size_start;
   vrsa_pkg::size_res_type             size_res;

   logic                               ram_we;
   logic [2*ADDR_BITS-1:0]             ram_wdata;
   logic [2*ADDR_BITS-1:0]             ram_q;

   logic [5:0]                         pab_w1;
   logic [5:0]                         pab_w;
   logic [AW-1:0]                      pmask_c;
   logic [4:0]                         num_sat;
   logic [CW-1:0]                      n_c;
   logic [AW-1:0]                      size_keep;
   logic [AW-1:0]                      abase_c;
   logic [AW-1:0]                      szmask_c;
   logic [AW-1:0]                      ent_b;
   logic [AW-1:0]                      ent_m;
   logic                               hit_now;
   logic                               issue;
   logic                               out_free;

   vrsa_size_log2 u_size (
      .clock  (clock),
      .reset  (reset),
      .start  (size_start),
      .length (req_length),
      .res    (size_res)
   );

   vrsa_ram #(
      .WIDTH (2 * ADDR_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (ram_wdata),
      .raddr (iss_ff[IDX_W-1:0]),
      .rdata (ram_q)
   );

   assign ram_wdata = {mw_ff[ADDR_BITS-1:0], bw_ff[ADDR_BITS-1:0]};

   always_comb begin
      pab_w1 = (csr_pab_ff < 6'(vrsa_pkg::MIN_PAB) || csr_pab_ff > 6'(vrsa_pkg::ADDR_W)) ?
               6'(vrsa_pkg::FALLBACK_BITS) : csr_pab_ff;
      pab_w  = (pab_w1 > 6'(ADDR_BITS)) ? 6'(ADDR_BITS) : pab_w1;
      pmask_c = (vrsa_pkg::ADDR_ONES >> (6'(vrsa_pkg::ADDR_W) - pab_w)) & vrsa_pkg::PAGE_MASK;
      num_sat = ({1'b0, csr_num_ff} > 5'(MAX_SLOTS)) ? 5'(MAX_SLOTS) : {1'b0, csr_num_ff};
      n_c     = CW'(num_sat);

      size_keep = vrsa_pkg::ADDR_ONES << lg_ff;
      abase_c   = base_ff & size_keep;
      szmask_c  = size_keep & pmask_ff;

      ent_b   = rd_wv_ff ? AW'(ram_q[ADDR_BITS-1:0]) : '0;
      ent_m   = rd_wv_ff ? AW'(ram_q[2*ADDR_BITS-1:ADDR_BITS]) : '0;
      hit_now = ent_m[vrsa_pkg::VALID_POS] && ((ent_b & pmask_ff) == abase_ff) &&
                (ent_b[vrsa_pkg::TYPE_W-1:0] == vrsa_pkg::WC_TYPE);

      issue    = (state_ff == S_SCAN) && (iss_ff < n_ff);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      csr_wc_in    = csr_wc_ff;
      csr_num_in   = csr_num_ff;
      csr_pab_in   = csr_pab_ff;
      op_in        = op_ff;
      base_in      = base_ff;
      sidx_in      = sidx_ff;
      mtype_in     = mtype_ff;
      vflag_in     = vflag_ff;
      wc_in        = wc_ff;
      n_in         = n_ff;
      pmask_in     = pmask_ff;
      lg_in        = lg_ff;
      abase_in     = abase_ff;
      szmask_in    = szmask_ff;
      iss_in       = issue ? iss_ff + CW'(1) : iss_ff;
      rd_vld_in    = issue;
      rd_idx_in    = iss_ff[IDX_W-1:0];
      rd_wv_in     = written_ff[iss_ff[IDX_W-1:0]];
      rd_last_in   = (iss_ff == n_ff - CW'(1));
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_bw_in    = hit_bw_ff;
      hit_mw_in    = hit_mw_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      bw_in        = bw_ff;
      mw_in        = mw_ff;
      wr_in        = wr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_abase_in = rsp_abase_ff;
      rsp_lg_in    = rsp_lg_ff;
      rsp_bw_in    = rsp_bw_ff;
      rsp_mw_in    = rsp_mw_ff;
      written_in   = written_ff;
      size_start   = 1'b0;
      ram_we       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            vrsa_pkg::CSR_WC_SUPPORTED:   csr_wc_in  = csr_wdata[0];
            vrsa_pkg::CSR_NUM_SLOTS:      csr_num_in = csr_wdata[vrsa_pkg::NUM_W-1:0];
            vrsa_pkg::CSR_PHYS_ADDR_BITS: csr_pab_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               base_in    = req_phys_base;
               sidx_in    = req_slot_index;
               mtype_in   = req_mem_type;
               vflag_in   = req_valid_flag;
               wc_in      = csr_wc_ff;
               n_in       = n_c;
               pmask_in   = pmask_c;
               size_start = 1'b1;
               state_in   = S_SIZE;
            end
         end
         S_SIZE: begin
            if (size_res.done) begin
               lg_in    = size_res.lg;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            abase_in  = abase_c;
            szmask_in = szmask_c;
            slot_in   = '0;
            bw_in     = '0;
            mw_in     = '0;
            wr_in     = 1'b0;
            iss_in    = '0;
            hit_in    = 1'b0;
            free_in   = 1'b0;
            state_in  = S_DONE;
            if (op_ff == vrsa_pkg::OP_PRESET) begin
               status_in = vrsa_pkg::STAT_PRESET;
               if ({2'b00, sidx_ff} < 5'(MAX_SLOTS)) begin
                  bw_in   = (base_ff & pmask_ff) | AW'(mtype_ff);
                  mw_in   = szmask_c | (vflag_ff ? vrsa_pkg::VALID_MASK : '0);
                  wr_in   = 1'b1;
                  slot_in = IDX_W'(sidx_ff);
               end
            end else if (!wc_ff) begin
               status_in = vrsa_pkg::STAT_UNSUP;
            end else if (n_ff == '0) begin
               status_in = vrsa_pkg::STAT_NO_SLOTS;
            end else begin
               status_in = vrsa_pkg::STAT_FULL;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (hit_now && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = rd_idx_ff;
                  hit_bw_in   = ent_b;
                  hit_mw_in   = ent_m;
               end
               if (!ent_m[vrsa_pkg::VALID_POS] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = rd_idx_ff;
               end
               if (rd_last_ff) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (hit_ff) begin
               status_in = vrsa_pkg::STAT_COVERED;
               slot_in   = hit_slot_ff;
               bw_in     = hit_bw_ff;
               mw_in     = hit_mw_ff;
            end else if (free_ff) begin
               status_in = vrsa_pkg::STAT_NEW;
               slot_in   = free_slot_ff;
               bw_in     = (abase_ff & pmask_ff) | AW'(vrsa_pkg::WC_TYPE);
               mw_in     = szmask_ff | vrsa_pkg::VALID_MASK;
               wr_in     = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = vrsa_pkg::SIDX_W'(slot_ff);
               rsp_abase_in  = abase_ff;
               rsp_lg_in     = lg_ff;
               rsp_bw_in     = bw_ff;
               rsp_mw_in     = mw_ff;
               if (wr_ff) begin
                  ram_we              = 1'b1;
                  written_in[slot_ff] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         written_ff   <= '0;
         csr_wc_ff    <= 1'b1;
         csr_num_ff   <= vrsa_pkg::NUM_W'(8);
         csr_pab_ff   <= 6'(vrsa_pkg::FALLBACK_BITS);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         written_ff   <= written_in;
         csr_wc_ff    <= csr_wc_in;
         csr_num_ff   <= csr_num_in;
         csr_pab_ff   <= csr_pab_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      base_ff       <= base_in;
      sidx_ff       <= sidx_in;
      mtype_ff      <= mtype_in;
      vflag_ff      <= vflag_in;
      wc_ff         <= wc_in;
      n_ff          <= n_in;
      pmask_ff      <= pmask_in;
      lg_ff         <= lg_in;
      abase_ff      <= abase_in;
      szmask_ff     <= szmask_in;
      iss_ff        <= iss_in;
      rd_idx_ff     <= rd_idx_in;
      rd_wv_ff      <= rd_wv_in;
      rd_last_ff    <= rd_last_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_bw_ff     <= hit_bw_in;
      hit_mw_ff     <= hit_mw_in;
      free_ff       <= free_in;
      free_slot_ff  <= free_slot_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      bw_ff         <= bw_in;
      mw_ff         <= mw_in;
      wr_ff         <= wr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_abase_ff  <= rsp_abase_in;
      rsp_lg_ff     <= rsp_lg_in;
      rsp_bw_ff     <= rsp_bw_in;
      rsp_mw_ff     <= rsp_mw_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_used    = rsp_slot_ff;
   assign rsp_region_base  = rsp_abase_ff;
   assign rsp_size_log2    = rsp_lg_ff;
   assign rsp_base_word    = rsp_bw_ff;
   assign rsp_mask_word    = rsp_mw_ff;

endmodule

[src/vrsa_ram.sv]
// ----------------------------------------------------------------------------
// vrsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module vrsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/vrsa_size_log2.sv]
// ----------------------------------------------------------------------------
// vrsa_size_log2
// Iterative ceiling log2 of a region length, clamped to 20..52. The search
// walks the length minus one from the top, one byte-wide window per cycle.
// ----------------------------------------------------------------------------
module vrsa_size_log2 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vrsa_pkg::LEN_W-1:0] length,
   output vrsa_pkg::size_res_type     res
);

   localparam int X_W = vrsa_pkg::LEN_W - vrsa_pkg::MIN_LOG2;

   logic                   busy_ff, busy_in;
   logic [X_W-1:0]         sreg_ff, sreg_in;
   logic [5:0]             pos_ff, pos_in;
   vrsa_pkg::size_res_type res_ff, res_in;

   logic [vrsa_pkg::LEN_W-1:0] len_m1;
   logic [vrsa_pkg::WIN_W-1:0] win;
   logic [2:0]                 jsel;
   logic [6:0]                 bitpos;
   logic [6:0]                 cand;

   always_comb begin
      len_m1 = (length == '0) ? '0 : length - vrsa_pkg::LEN_W'(1);
      win    = sreg_ff[X_W-1 -: vrsa_pkg::WIN_W];
      jsel   = 3'd0;
      for (int j = 0; j < vrsa_pkg::WIN_W; j++) begin
         if (win[j]) begin
            jsel = 3'(j);
         end
      end
      bitpos = 7'(pos_ff) + 7'(jsel) - 7'(vrsa_pkg::WIN_W - 1);
      cand   = bitpos + 7'(vrsa_pkg::MIN_LOG2 + 1);

      busy_in = busy_ff;
      sreg_in = sreg_ff;
      pos_in  = pos_ff;
      res_in  = '{done: 1'b0, lg: res_ff.lg};

      if (start) begin
         busy_in = 1'b1;
         sreg_in = len_m1[vrsa_pkg::LEN_W-1:vrsa_pkg::MIN_LOG2];
         pos_in  = 6'(X_W - 1);
      end else if (busy_ff) begin
         if (win != '0) begin
            busy_in     = 1'b0;
            res_in.done = 1'b1;
            res_in.lg   = (cand > 7'(vrsa_pkg::MAX_LOG2)) ?
                          vrsa_pkg::LG_W'(vrsa_pkg::MAX_LOG2) : vrsa_pkg::LG_W'(cand);
         end else if (pos_ff < 6'(vrsa_pkg::WIN_W)) begin
            busy_in     = 1'b0;
            res_in.done = 1'b1;
            res_in.lg   = vrsa_pkg::LG_W'(vrsa_pkg::MIN_LOG2);
         end else begin
            sreg_in = sreg_ff << vrsa_pkg::WIN_W;
            pos_in  = pos_ff - 6'(vrsa_pkg::WIN_W);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         res_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         res_ff  <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      sreg_ff <= sreg_in;
      pos_ff  <= pos_in;
   end

   assign res = res_ff;

endmodule

[src/vrsa_checker.sv]
// ----------------------------------------------------------------------------
// vrsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [vrsa_pkg::STATUS_W-1:0]     rsp_status,
   input logic [vrsa_pkg::SIDX_W-1:0]       rsp_slot_used,
   input logic [vrsa_pkg::LG_W-1:0]         rsp_size_log2,
   input logic [vrsa_pkg::ADDR_W-1:0]       rsp_base_word,
   input logic [vrsa_pkg::ADDR_W-1:0]       rsp_mask_word
);

   logic req_take;
   logic rsp_held;
   logic failed;
   logic fresh;
   logic size_ok;
   logic zero_out;
   logic new_ok;

   assign req_take = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;
   assign failed   = rsp_valid && (rsp_status == vrsa_pkg::STAT_UNSUP ||
                                   rsp_status == vrsa_pkg::STAT_NO_SLOTS ||
                                   rsp_status == vrsa_pkg::STAT_FULL);
   assign fresh    = rsp_valid && (rsp_status == vrsa_pkg::STAT_NEW);
   assign size_ok  = (rsp_size_log2 >= 6'(vrsa_pkg::MIN_LOG2)) &&
                     (rsp_size_log2 <= 6'(vrsa_pkg::MAX_LOG2));
   assign zero_out = (rsp_slot_used == '0) && (rsp_base_word == '0) && (rsp_mask_word == '0);
   assign new_ok   = rsp_mask_word[vrsa_pkg::VALID_POS] &&
                     (rsp_base_word[vrsa_pkg::TYPE_W-1:0] == vrsa_pkg::WC_TYPE);

   `VRSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_base_word), "held response changed")
   `VRSA_ASSERT_NEXT(a_one_request, clock, reset, req_take, req_stall, "second request taken while busy")
   `VRSA_ASSERT_NOW(a_fail_zero, clock, reset, failed, zero_out, "failed request reports slot or words")
   `VRSA_ASSERT_NOW(a_size_range, clock, reset, rsp_valid, size_ok, "size out of range")
   `VRSA_ASSERT_NOW(a_new_valid, clock, reset, fresh, new_ok, "new slot lacks valid or type")

endmodule

bind variable_range_slot_allocator vrsa_checker u_vrsa_checker (.*);
